>>> rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg
// Shared types and constants for the streaming top-k tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package stk_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CFG_W  = 7;
  localparam logic [CFG_W-1:0] KEEP_RESET = CFG_W'(10);

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_CHECK = 1'b1;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // offer accepted this cycle
    logic grow;  // store not yet full, the chain lengthens by one
    logic rot;   // rotate occupied cells towards the head
  } cell_cmd_t;

endpackage

`default_nettype wire

>>> rtl/stk_in_if.sv
// ----------------------------------------------------------------------------
// stk_in_if
// Input channel: valid/ready with an operation code and offered value.
// ----------------------------------------------------------------------------
`default_nettype none

interface stk_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/stk_out_if.sv
// ----------------------------------------------------------------------------
// stk_out_if
// Result channel: valid/ready with a kept value and end-of-check flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface stk_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] top_value;
  logic        last;
  logic        empty_res;

  modport source (output valid, output top_value, output last, output empty_res,
                  input ready);
  modport sink   (input valid, input top_value, input last, input empty_res,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/stk_cell.sv
// ----------------------------------------------------------------------------
// stk_cell
// One slot of the sorted chain: holds a value and an occupied flag, takes
// part in sorted insertion and in rotation during readout.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_cell (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  stk_pkg::cell_cmd_t       cmd_i,
  input  wire [stk_pkg::VAL_W-1:0] value_i,
  input  wire [stk_pkg::VAL_W-1:0] prev_val_i,
  input  wire                      prev_take_i,
  input  wire                      prev_occ_i,
  input  wire [stk_pkg::VAL_W-1:0] next_val_i,
  input  wire                      next_occ_i,
  input  wire [stk_pkg::VAL_W-1:0] head_val_i,
  output logic [stk_pkg::VAL_W-1:0] val_o,
  output logic                     take_o,
  output logic                     occ_o
);
  import stk_pkg::*;

  logic [VAL_W-1:0] val_q, val_d;
  logic             occ_q, occ_d;
  logic             take;

  // empty slots sit below anything offered
  assign take = !occ_q || (value_i > val_q);

  always_comb begin
    val_d = val_q;
    occ_d = occ_q;
    if (cmd_i.ins && (occ_q || (cmd_i.grow && prev_occ_i))) begin
      occ_d = 1'b1;
      if (take) begin
        val_d = prev_take_i ? prev_val_i : value_i;
      end
    end else if (cmd_i.rot && occ_q) begin
      // tail of the occupied run wraps round to the head value
      val_d = next_occ_i ? next_val_i : head_val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign take_o = take;
  assign occ_o  = occ_q;

endmodule

`default_nettype wire

>>> rtl/streaming_top_k_tracker_top.sv
// ----------------------------------------------------------------------------
// streaming_top_k_tracker_top
// Keeps the k largest unsigned values of a stream in a sorted cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : beats carry func (0 offer, 1 check) and value.
//   out_o : one beat per kept value on a check, largest first, last set on
//           the final beat; a check of an empty store gives a single beat
//           with top_value 0, last and empty_res set.
//   cfg_we_i/cfg_wdata_i : writes k (0 acts as 1, above MAX_KEEP as MAX_KEEP).
// Throughput: offers may come every cycle while no check is being sent; all
//   cells compare against the value in parallel and shift as the offer is taken.
// A check of n kept values gives n result beats, an empty one a single beat:
//   the chain rotates one place per beat through the head cell, so it is back
//   in order after the last beat. The check beat moves the state to sending,
//   and the first result is loaded from there into the output register.
// Input is not taken while a check is being sent out; the last result beat
//   sits in an output register, so the next item is taken alongside it.
// A stalled receiver holds the result beat and freezes the rotation.
// Reset empties the store and sets k to 10; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module streaming_top_k_tracker_top #(
  parameter int unsigned MAX_KEEP = 64
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        cfg_we_i,
  input  wire [stk_pkg::CFG_W-1:0]   cfg_wdata_i,
  stk_in_if.sink                     in_i,
  stk_out_if.source                  out_o
);
  import stk_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_KEEP + 1);

  typedef enum logic {
    S_IDLE,
    S_SEND
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] keep_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic             ovalid_q, ovalid_d;
  logic [VAL_W-1:0] oval_q, oval_d;
  logic             olast_q, olast_d;
  logic             oempty_q, oempty_d;

  logic [CNT_W-1:0] k_eff;
  logic             in_acc;
  logic             load;
  cell_cmd_t        cmd;

  logic [VAL_W-1:0] cell_val  [MAX_KEEP];
  logic             cell_take [MAX_KEEP];
  logic             cell_occ  [MAX_KEEP];

  always_comb begin
    if (keep_q == '0) begin
      k_eff = CNT_W'(1);
    end else if (keep_q > CFG_W'(MAX_KEEP)) begin
      k_eff = CNT_W'(MAX_KEEP);
    end else begin
      k_eff = keep_q[CNT_W-1:0];
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign load       = (state_q == S_SEND) && (!ovalid_q || out_o.ready);

  assign cmd.ins  = in_acc && (in_i.func == FUNC_OFFER);
  assign cmd.grow = (count_q < k_eff);
  assign cmd.rot  = load && (count_q != '0);

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    logic [VAL_W-1:0] nxt_val;
    logic             nxt_occ;

    if (g + 1 < MAX_KEEP) begin : g_mid
      assign nxt_val = cell_val[g+1];
      assign nxt_occ = cell_occ[g+1];
    end else begin : g_end
      // empty slot below the tail
      assign nxt_val = '0;
      assign nxt_occ = 1'b0;
    end

    if (g > 0) begin : g_prev
      stk_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .value_i     (in_i.value),
        .prev_val_i  (cell_val[g-1]),
        .prev_take_i (cell_take[g-1]),
        .prev_occ_i  (cell_occ[g-1]),
        .next_val_i  (nxt_val),
        .next_occ_i  (nxt_occ),
        .head_val_i  (cell_val[0]),
        .val_o       (cell_val[g]),
        .take_o      (cell_take[g]),
        .occ_o       (cell_occ[g])
      );
    end else begin : g_head
      // a virtual full cell above the head that never takes
      stk_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .cmd_i       (cmd),
        .value_i     (in_i.value),
        .prev_val_i  ('0),
        .prev_take_i (1'b0),
        .prev_occ_i  (1'b1),
        .next_val_i  (nxt_val),
        .next_occ_i  (nxt_occ),
        .head_val_i  (cell_val[0]),
        .val_o       (cell_val[g]),
        .take_o      (cell_take[g]),
        .occ_o       (cell_occ[g])
      );
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rem_d    = rem_q;
    ovalid_d = ovalid_q;
    oval_d   = oval_q;
    olast_d  = olast_q;
    oempty_d = oempty_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (cmd.ins && cmd.grow) begin
          count_d = count_q + CNT_W'(1);
        end
        if (in_acc && (in_i.func == FUNC_CHECK)) begin
          rem_d   = count_q;
          state_d = S_SEND;
        end
      end
      S_SEND: begin
        if (load) begin
          ovalid_d = 1'b1;
          if (count_q == '0) begin
            oval_d   = '0;
            olast_d  = 1'b1;
            oempty_d = 1'b1;
            state_d  = S_IDLE;
          end else begin
            oval_d   = cell_val[0];
            olast_d  = (rem_q == CNT_W'(1));
            oempty_d = 1'b0;
            rem_d    = rem_q - CNT_W'(1);
            if (rem_q == CNT_W'(1)) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rem_q    <= '0;
      ovalid_q <= 1'b0;
      oval_q   <= '0;
      olast_q  <= 1'b0;
      oempty_q <= 1'b0;
      keep_q   <= KEEP_RESET;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      ovalid_q <= ovalid_d;
      oval_q   <= oval_d;
      olast_q  <= olast_d;
      oempty_q <= oempty_d;
      if (cfg_we_i) begin
        keep_q <= cfg_wdata_i;
      end
    end
  end

  assign out_o.valid     = ovalid_q;
  assign out_o.top_value = oval_q;
  assign out_o.last      = olast_q;
  assign out_o.empty_res = oempty_q;

endmodule

`default_nettype wire

>>> rtl/stk_checker.sv
// ----------------------------------------------------------------------------
// stk_checker
// Port-level checks on the top-k tracker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module stk_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        in_valid_i,
  input wire        in_ready_i,
  input wire        in_func_i,
  input wire        out_valid_i,
  input wire        out_ready_i,
  input wire [31:0] out_top_value_i,
  input wire        out_last_i,
  input wire        out_empty_res_i
);
  import stk_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_top_value_i)
      && $stable(out_last_i) && $stable(out_empty_res_i))
    else $error("result beat changed while stalled");

  // no new item while a check is still being sent
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("input taken mid-check");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_res_i |-> out_last_i && (out_top_value_i == '0))
    else $error("empty result not a single zero beat");

  a_stream_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside a check burst");

  a_offer_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FUNC_OFFER) && !out_valid_i
      |=> !out_valid_i)
    else $error("offer produced a result");

endmodule

bind streaming_top_k_tracker_top stk_checker u_stk_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .in_func_i       (in_i.func),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_top_value_i (out_o.top_value),
  .out_last_i      (out_o.last),
  .out_empty_res_i (out_o.empty_res)
);

`default_nettype wire
